/* hw/rtl/sfd_pkg.sv */
// Shared constants for the SBUS frame decoder: frame layout, marker bytes,
// channel packing and link status codes. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame markers
  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  // Byte positions within a frame (the start byte sits at position 0)
  localparam int unsigned POS_W         = 5;
  localparam logic [POS_W-1:0] LAST_DATA_POS = 5'd22;
  localparam logic [POS_W-1:0] STATUS_POS    = 5'd23;
  localparam logic [POS_W-1:0] END_POS       = 5'd24;

  // Channel packing
  localparam int unsigned CH_W     = 11;
  localparam int unsigned NUM_CH   = 16;
  localparam int unsigned CH_IDX_W = $clog2(NUM_CH);
  localparam int unsigned ACC_W    = CH_W + 7;       // leftover bits plus one byte
  localparam int unsigned CNT_W    = $clog2(ACC_W + 1);

  localparam logic [CH_IDX_W-1:0] LAST_CH_HALF = CH_IDX_W'(NUM_CH / 2 - 1);
  localparam logic [CH_IDX_W-1:0] LAST_CH_ALL  = CH_IDX_W'(NUM_CH - 1);

  // Status byte flags
  localparam int unsigned LOST_BIT     = 2;
  localparam int unsigned FAILSAFE_BIT = 3;

  // Link status codes
  localparam logic [1:0] LINK_OK       = 2'd0;
  localparam logic [1:0] LINK_LOST     = 2'd1;
  localparam logic [1:0] LINK_FAILSAFE = 2'd2;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_ALL_CH = 1'b0;   // register index, taken from paddr[2]

endpackage

/* hw/rtl/sbus_frame_decoder_top.sv */
// SBUS frame decoder top level: byte unpacker, double-banked channel memory
// and result emitter. Depends on sfd_pkg.
//
// Usage:
//   Input channel (rx_byte_i, in_valid_i, in_stall_o) takes one UART byte per
//   beat. Bytes outside a frame other than 0x0F are dropped. A frame is the
//   start byte plus 24 bytes; the 25th byte must be 0x00 or the frame gives
//   nothing. Channels are unpacked on the fly as bytes arrive and written to a
//   32 x 11 bit synchronous memory, one bank per frame (ping-pong).
//   Output channel (out_valid_o, out_stall_i) carries one channel per beat:
//   channel_index_o, channel_value_o, link_status_o, last_channel_o.
//   Input bytes are taken one per cycle while in_stall_o is low. After a good
//   end byte channels pass the emitter, read stage and output register, one
//   per cycle (8 or 16 beats, set by all_channels_enable at byte address 0)
//   while the receiver does not stall; the single memory read port sets the rate.
//   Bytes of the next frame are accepted during a burst; only the end byte of
//   that next frame is held off (in_stall_o) until the burst has been issued.
//   A receiver stall holds the output beat; memory reads pause once the read
//   stage is full. Reset returns to waiting for a start byte, clears the burst
//   and the register; memory contents are undefined until written.
`timescale 1ns / 1ps

module sbus_frame_decoder_top import sfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic [7:0]         rx_byte_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  // channel output
  output logic [3:0]         channel_index_o,
  output logic [10:0]        channel_value_o,
  output logic [1:0]         link_status_o,
  output logic               last_channel_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned MEM_AW = CH_IDX_W + 1;

  // Configuration register
  logic all_ch_q;

  // Receive state
  logic                in_frame_q;
  logic [POS_W-1:0]    pos_q;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CH_IDX_W-1:0] wr_ch_q;
  logic                wr_bank_q;
  logic [7:0]          status_byte_q;

  // Emitter state
  logic                emit_busy_q;
  logic                emit_bank_q;
  logic [CH_IDX_W-1:0] emit_ch_q;
  logic [CH_IDX_W-1:0] emit_last_q;
  logic [1:0]          emit_status_q;

  // Read stage and output register
  logic                rd_v_q;
  logic [CH_IDX_W-1:0] rd_idx_q;
  logic                rd_last_q;
  logic [1:0]          rd_status_q;
  logic [CH_W-1:0]     rd_data_q;
  logic                out_v_q;
  logic [CH_IDX_W-1:0] out_idx_q;
  logic                out_last_q;
  logic [1:0]          out_status_q;
  logic [CH_W-1:0]     out_data_q;

  // Channel memory: two banks of NUM_CH entries
  logic [CH_W-1:0] ch_mem [2**MEM_AW];

  logic                in_acc;
  logic [POS_W-1:0]    pos_nxt;
  logic [ACC_W-1:0]    merged;
  logic [CNT_W-1:0]    cnt_sum;
  logic                ch_full;
  logic                mem_we;
  logic                frame_ok;
  logic [1:0]          status_code;
  logic                out_take;
  logic                rd_issue;
  logic                cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ALL_CH) ? {31'd0, all_ch_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_ch_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_ALL_CH)) begin
      all_ch_q <= pwdata[0];
    end
  end

  // Hold off the end byte of a frame while the previous burst still reads
  assign in_stall_o = emit_busy_q && in_frame_q && (pos_q == STATUS_POS);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_nxt    = pos_q + POS_W'(1);

  // Unpack: append the byte above the leftover bits, cut one channel off
  assign merged  = acc_q | (ACC_W'(rx_byte_i) << cnt_q);
  assign cnt_sum = cnt_q + CNT_W'(8);
  assign ch_full = cnt_sum >= CNT_W'(CH_W);
  assign mem_we  = in_acc && in_frame_q && (pos_nxt <= LAST_DATA_POS) && ch_full;

  assign frame_ok = in_acc && in_frame_q && (pos_nxt == END_POS) && (rx_byte_i == END_BYTE);

  // Decode link status, lost before failsafe
  always_comb begin
    if (status_byte_q[LOST_BIT]) begin
      status_code = LINK_LOST;
    end else if (status_byte_q[FAILSAFE_BIT]) begin
      status_code = LINK_FAILSAFE;
    end else begin
      status_code = LINK_OK;
    end
  end

  // Advance the receive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
      wr_ch_q    <= '0;
      wr_bank_q  <= 1'b0;
    end else if (in_acc) begin
      if (!in_frame_q) begin
        if (rx_byte_i == START_BYTE) begin
          in_frame_q <= 1'b1;
          pos_q      <= '0;
          acc_q      <= '0;
          cnt_q      <= '0;
          wr_ch_q    <= '0;
        end
      end else if (pos_nxt == END_POS) begin
        in_frame_q <= 1'b0;
        pos_q      <= '0;
        if (frame_ok) begin
          wr_bank_q <= !wr_bank_q;
        end
      end else begin
        pos_q <= pos_nxt;
        if (pos_nxt <= LAST_DATA_POS) begin
          if (ch_full) begin
            acc_q   <= merged >> CH_W;
            cnt_q   <= cnt_sum - CNT_W'(CH_W);
            wr_ch_q <= wr_ch_q + CH_IDX_W'(1);
          end else begin
            acc_q <= merged;
            cnt_q <= cnt_sum;
          end
        end
      end
    end
  end

  // Capture the status byte of the frame being received
  always_ff @(posedge clk_i) begin
    if (in_acc && in_frame_q && (pos_nxt == STATUS_POS)) begin
      status_byte_q <= rx_byte_i;
    end
  end

  // Read-issue control: read when the read stage is empty or moves on
  assign out_take = !out_v_q || !out_stall_i;
  assign rd_issue = emit_busy_q && (!rd_v_q || out_take);

  // Channel memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ch_mem[{wr_bank_q, wr_ch_q}] <= merged[CH_W-1:0];
    end
    if (rd_issue) begin
      rd_data_q <= ch_mem[{emit_bank_q, emit_ch_q}];
    end
  end

  // Emitter: walk the channels of a finished frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      emit_ch_q   <= '0;
    end else if (frame_ok) begin
      emit_busy_q <= 1'b1;
      emit_ch_q   <= '0;
    end else if (rd_issue) begin
      emit_ch_q <= emit_ch_q + CH_IDX_W'(1);
      if (emit_ch_q == emit_last_q) begin
        emit_busy_q <= 1'b0;
      end
    end
  end

  // Latch burst parameters at the end byte
  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      emit_bank_q   <= wr_bank_q;
      emit_last_q   <= all_ch_q ? LAST_CH_ALL : LAST_CH_HALF;
      emit_status_q <= status_code;
    end
  end

  // Read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (rd_issue) begin
      rd_v_q <= 1'b1;
    end else if (out_take) begin
      rd_v_q <= 1'b0;
    end
  end

  // Tag data travelling with the read
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_idx_q    <= emit_ch_q;
      rd_last_q   <= (emit_ch_q == emit_last_q);
      rd_status_q <= emit_status_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && rd_v_q) begin
      out_idx_q    <= rd_idx_q;
      out_last_q   <= rd_last_q;
      out_status_q <= rd_status_q;
      out_data_q   <= rd_data_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_data_q;
  assign link_status_o   = out_status_q;
  assign last_channel_o  = out_last_q;

endmodule
